// ===== hw/rtl/orm_pkg.sv =====
// Shared types and constants of the offset-removed RMS meter.
`default_nettype none

package orm_pkg;

    localparam int LEN_W      = 13;                 // window length register width
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd1000;
    localparam int LVL_W      = 16;                 // result fields, 1/16 mV
    localparam int SQ_W       = 48;                 // square sum width
    localparam int DIV_STEPS  = SQ_W;               // one quotient bit per cycle
    localparam int SQRT_STEPS = SQ_W / 2;           // one root bit per cycle
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    // Classification attached to each sample by the front end
    typedef struct packed {
        logic             rms;   // sample belongs to the rms window
        logic             last;  // sample closes its window
        logic [LEN_W-1:0] len;   // effective window length
    } t_tag;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT
    } t_ds_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MAC,
        BK_ODIV,
        BK_RDIV,
        BK_EMIT
    } t_bk_state;

    typedef struct packed {
        logic res_load;   // result moves into the output register
        logic unit_busy;  // divide / root unit is running
    } t_bk_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/orm_queue.sv =====
// Short FIFO between the front end and the back end.
`default_nettype none

module orm_queue #(
    parameter int W = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);

    logic [W-1:0]                 r_mem [orm_pkg::Q_DEPTH];
    logic [orm_pkg::Q_PTR_W-1:0]  r_wp;
    logic [orm_pkg::Q_PTR_W-1:0]  r_rp;
    logic [orm_pkg::Q_PTR_W:0]    r_cnt;

    assign o_full  = (r_cnt == (orm_pkg::Q_PTR_W + 1)'(orm_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/orm_front.sv =====
// Front end: window length register, sample acceptance and window tagging.
`default_nettype none

module orm_front #(
    parameter int MAX_WINDOW = 4096
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [orm_pkg::LEN_W-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic                      i_q_full,
    output logic                           o_push,
    output orm_pkg::t_tag                  o_tag
);

    logic [orm_pkg::LEN_W-1:0] r_len;
    logic [orm_pkg::LEN_W-1:0] r_count;
    logic                      r_rms;
    logic [orm_pkg::LEN_W-1:0] w_len0;
    logic [orm_pkg::LEN_W-1:0] w_eff;
    logic                      w_last;

    // zero means one, clamp at the largest window
    always_comb begin
        w_len0 = (r_len == '0) ? orm_pkg::LEN_W'(1) : r_len;
        w_eff  = (32'(w_len0) > 32'(MAX_WINDOW)) ? orm_pkg::LEN_W'(MAX_WINDOW) : w_len0;
        w_last = (({1'b0, r_count} + 1'b1) >= {1'b0, w_eff});
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_q_full;
    assign o_push      = i_valid && !i_q_full;
    assign o_tag       = '{rms: r_rms, last: w_last, len: w_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= orm_pkg::LEN_RESET;
            r_count <= '0;
            r_rms   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_len <= i_cfg_data;
            end
            if (o_push) begin
                if (w_last) begin
                    r_count <= '0;
                    r_rms   <= !r_rms;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/orm_divsqrt.sv =====
// Shared bit-serial divider with optional integer square root of the quotient.
`default_nettype none

module orm_divsqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_do_sqrt,
    input  wire logic [orm_pkg::SQ_W-1:0]  i_dividend,
    input  wire logic [orm_pkg::LEN_W-1:0] i_divisor,
    output logic                           o_done,
    output logic                           o_busy,
    output logic [orm_pkg::LVL_W-1:0]      o_result
);

    localparam int SQ_W   = orm_pkg::SQ_W;
    localparam int REM_W  = orm_pkg::LEN_W;
    localparam int STEP_W = orm_pkg::STEP_W;

    orm_pkg::t_ds_state r_state;
    orm_pkg::t_ds_state n_state;
    logic               r_done;
    logic               n_done;
    logic [STEP_W-1:0]  r_cnt;
    logic [SQ_W-1:0]    r_a;      // dividend in, quotient out, then root remainder
    logic [REM_W-1:0]   r_rem;
    logic [REM_W-1:0]   r_d;
    logic               r_sqrt;
    logic [SQ_W-1:0]    r_res;
    logic [SQ_W-1:0]    r_bit;

    logic [REM_W:0]     w_trial;
    logic [REM_W:0]     w_sub;
    logic               w_qbit;
    logic [SQ_W-1:0]    w_sum;
    logic               w_sge;
    logic               w_div_last;
    logic               w_sqrt_last;

    always_comb begin
        w_trial     = {r_rem, r_a[SQ_W-1]};
        w_qbit      = (w_trial >= {1'b0, r_d});
        w_sub       = w_trial - {1'b0, r_d};
        w_sum       = r_res + r_bit;
        w_sge       = (r_a >= w_sum);
        w_div_last  = (r_cnt == STEP_W'(orm_pkg::DIV_STEPS - 1));
        w_sqrt_last = (r_cnt == STEP_W'(orm_pkg::SQRT_STEPS - 1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            orm_pkg::DS_IDLE: begin
                if (i_start) begin
                    n_state = orm_pkg::DS_DIV;
                end
            end
            orm_pkg::DS_DIV: begin
                if (w_div_last) begin
                    n_state = r_sqrt ? orm_pkg::DS_SQRT : orm_pkg::DS_IDLE;
                end
            end
            orm_pkg::DS_SQRT: begin
                if (w_sqrt_last) begin
                    n_state = orm_pkg::DS_IDLE;
                end
            end
            default: n_state = orm_pkg::DS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_done = ((r_state == orm_pkg::DS_DIV) && w_div_last && !r_sqrt) ||
                 ((r_state == orm_pkg::DS_SQRT) && w_sqrt_last);
        o_done   = r_done;
        o_busy   = (r_state != orm_pkg::DS_IDLE);
        o_result = r_sqrt ? r_res[orm_pkg::LVL_W-1:0] : r_a[orm_pkg::LVL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= orm_pkg::DS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            orm_pkg::DS_IDLE: begin
                if (i_start) begin
                    r_a    <= i_dividend;
                    r_rem  <= '0;
                    r_d    <= i_divisor;
                    r_sqrt <= i_do_sqrt;
                    r_cnt  <= '0;
                end
            end
            orm_pkg::DS_DIV: begin
                r_a   <= {r_a[SQ_W-2:0], w_qbit};
                r_rem <= w_qbit ? w_sub[REM_W-1:0] : w_trial[REM_W-1:0];
                r_cnt <= w_div_last ? '0 : r_cnt + 1'b1;
                r_res <= '0;
                r_bit <= SQ_W'(1) << (SQ_W - 2);
            end
            orm_pkg::DS_SQRT: begin
                if (w_sge) begin
                    r_a   <= r_a - w_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/orm_back.sv =====
// Back end: window accumulation, divide / root sequencing and result register.
`default_nettype none

module orm_back #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_empty,
    input  wire logic [SAMPLE_BITS-1:0]       i_q_sample,
    input  wire orm_pkg::t_tag                i_q_tag,
    output logic                              o_pop,
    output logic                              o_start,
    output logic                              o_do_sqrt,
    output logic [orm_pkg::SQ_W-1:0]          o_dividend,
    output logic [orm_pkg::LEN_W-1:0]         o_divisor,
    input  wire logic                         i_done,
    input  wire logic                         i_busy,
    input  wire logic [orm_pkg::LVL_W-1:0]    i_result,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [orm_pkg::LVL_W-1:0]         o_offset,
    output logic [orm_pkg::LVL_W-1:0]         o_rms,
    output orm_pkg::t_bk_stat                 o_stat
);

    localparam int SUM_W = SAMPLE_BITS + orm_pkg::LEN_W;
    localparam int MAG_W = (SAMPLE_BITS + 4 > orm_pkg::LVL_W) ? SAMPLE_BITS + 4 : orm_pkg::LVL_W;
    localparam int SQ_W  = orm_pkg::SQ_W;

    orm_pkg::t_bk_state          r_state;
    orm_pkg::t_bk_state          n_state;
    logic [SUM_W-1:0]            r_sum;
    logic [SQ_W-1:0]             r_sq;
    logic [orm_pkg::LVL_W-1:0]   r_off;
    logic [orm_pkg::LVL_W-1:0]   r_rms_val;
    logic [MAG_W-1:0]            r_mag;
    logic                        r_last;
    logic [orm_pkg::LEN_W-1:0]   r_len;
    logic                        r_ovalid;
    logic [orm_pkg::LVL_W-1:0]   r_out_off;
    logic [orm_pkg::LVL_W-1:0]   r_out_rms;

    logic [SUM_W-1:0]            w_sum_nx;
    logic signed [MAG_W:0]       w_diff;
    logic [MAG_W:0]              w_abs;
    logic [2*MAG_W-1:0]          w_prod;
    logic [SQ_W-1:0]             w_sq_nx;
    logic                        w_take;
    logic                        w_load;

    always_comb begin
        w_sum_nx = r_sum + SUM_W'(i_q_sample);
        w_diff   = $signed((MAG_W + 1)'({i_q_sample, 4'b0000})) -
                   $signed((MAG_W + 1)'(r_off));
        w_abs    = w_diff[MAG_W] ? (MAG_W + 1)'(-w_diff) : (MAG_W + 1)'(w_diff);
        w_prod   = r_mag * r_mag;
        w_sq_nx  = r_sq + SQ_W'(w_prod);
        w_take   = (r_state == orm_pkg::BK_IDLE) && !i_q_empty;
        w_load   = (r_state == orm_pkg::BK_EMIT) && (!r_ovalid || i_ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            orm_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_tag.rms) begin
                        n_state = orm_pkg::BK_MAC;
                    end else if (i_q_tag.last) begin
                        n_state = orm_pkg::BK_ODIV;
                    end
                end
            end
            orm_pkg::BK_MAC: begin
                n_state = r_last ? orm_pkg::BK_RDIV : orm_pkg::BK_IDLE;
            end
            orm_pkg::BK_ODIV: begin
                if (i_done) begin
                    n_state = orm_pkg::BK_IDLE;
                end
            end
            orm_pkg::BK_RDIV: begin
                if (i_done) begin
                    n_state = orm_pkg::BK_EMIT;
                end
            end
            orm_pkg::BK_EMIT: begin
                if (w_load) begin
                    n_state = orm_pkg::BK_IDLE;
                end
            end
            default: n_state = orm_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop      = w_take;
        o_start    = (w_take && !i_q_tag.rms && i_q_tag.last) ||
                     ((r_state == orm_pkg::BK_MAC) && r_last);
        o_do_sqrt  = (r_state == orm_pkg::BK_MAC);
        o_dividend = (r_state == orm_pkg::BK_MAC) ? w_sq_nx : SQ_W'({w_sum_nx, 4'b0000});
        o_divisor  = (r_state == orm_pkg::BK_MAC) ? r_len : i_q_tag.len;
        o_valid    = r_ovalid;
        o_offset   = r_out_off;
        o_rms      = r_out_rms;
        o_stat     = '{res_load: w_load, unit_busy: i_busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= orm_pkg::BK_IDLE;
            r_sum    <= '0;
            r_sq     <= '0;
            r_off    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take && !i_q_tag.rms) begin
                r_sum <= i_q_tag.last ? '0 : w_sum_nx;
            end
            if (r_state == orm_pkg::BK_MAC) begin
                r_sq <= r_last ? '0 : w_sq_nx;
            end
            if ((r_state == orm_pkg::BK_ODIV) && i_done) begin
                r_off <= i_result;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_q_tag.rms) begin
            r_mag  <= w_abs[MAG_W-1:0];
            r_last <= i_q_tag.last;
            r_len  <= i_q_tag.len;
        end
        if ((r_state == orm_pkg::BK_RDIV) && i_done) begin
            r_rms_val <= i_result;
        end
        if (w_load) begin
            r_out_off <= r_off;
            r_out_rms <= r_rms_val;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/offset_removed_rms_meter.sv =====
// Back end: an offset-window sample is taken in BK_IDLE; an rms-window sample also passes BK_MAC.
// Offset window close: bit-serial divide; rms window close: bit-serial divide
// plus integer root, then the result is loaded into the output register in BK_EMIT.
// Throughput: front takes one sample per cycle into a 4-entry queue while it is not full;
// the back end takes no samples while the shared divide / root unit runs.
// Reset: synchronous active-low; window length returns to 1000, offset phase, sums zero.
`default_nettype none

module offset_removed_rms_meter #(
    parameter int MAX_WINDOW  = 4096,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // window length write channel
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [orm_pkg::LEN_W-1:0]  i_cfg_data,
    // sample stream
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] i_s_tdata,  // [SAMPLE_BITS-1:0] sample_mv
    // result stream
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [2*orm_pkg::LVL_W-1:0]     o_m_tdata   // [15:0] offset_level, [31:16] rms_level
);

    localparam int Q_W = SAMPLE_BITS + $bits(orm_pkg::t_tag);

    // front to queue
    logic                        w_push;
    orm_pkg::t_tag               w_tag;
    logic                        w_q_full;
    logic                        w_q_empty;
    logic [Q_W-1:0]              w_q_data;
    logic                        w_pop;

    // back to divide / root unit
    logic                        w_start;
    logic                        w_do_sqrt;
    logic [orm_pkg::SQ_W-1:0]    w_dividend;
    logic [orm_pkg::LEN_W-1:0]   w_divisor;
    logic                        w_done;
    logic                        w_busy;
    logic [orm_pkg::LVL_W-1:0]   w_result;
    orm_pkg::t_bk_stat           w_stat;

    logic [orm_pkg::LVL_W-1:0]   w_offset;
    logic [orm_pkg::LVL_W-1:0]   w_rms;

    // Front end: owns the window length, counts samples and marks each one with its
    // window and whether it closes it. Sample bits above SAMPLE_BITS are dropped at the queue input.
    orm_front #(
        .MAX_WINDOW(MAX_WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_tag       (w_tag)
    );

    // Queue lets the front keep taking samples while the back end divides.
    orm_queue #(
        .W(Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_tag, i_s_tdata[SAMPLE_BITS-1:0]}),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    // Back end: sums samples, then squared deviations, and runs the shared unit at
    // each window close. The output register decouples the result stream.
    orm_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_sample (w_q_data[SAMPLE_BITS-1:0]),
        .i_q_tag    (orm_pkg::t_tag'(w_q_data[Q_W-1:SAMPLE_BITS])),
        .o_pop      (w_pop),
        .o_start    (w_start),
        .o_do_sqrt  (w_do_sqrt),
        .o_dividend (w_dividend),
        .o_divisor  (w_divisor),
        .i_done     (w_done),
        .i_busy     (w_busy),
        .i_result   (w_result),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_offset   (w_offset),
        .o_rms      (w_rms),
        .o_stat     (w_stat)
    );

    // One quotient bit per cycle, then one root bit per cycle for the rms window.
    orm_divsqrt u_divsqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_do_sqrt  (w_do_sqrt),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_done),
        .o_busy     (w_busy),
        .o_result   (w_result)
    );

    assign o_m_tdata = {w_rms, w_offset};

    // A result is only loaded once the shared unit has finished.
    a_load_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_load |-> !w_stat.unit_busy)
        else $error("result loaded while divide unit busy");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.res_load |=> o_m_tvalid)
        else $error("loaded result not presented");

    // Queue flags are mutually exclusive.
    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_full && w_q_empty))
        else $error("queue both full and empty");

    // No result right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
